>>> hw/rtl/sms_pkg.sv
// sms_pkg: shared types, widths and the key builder for the scored move sorter
// used by sms_ctrl, sms_datapath and scored_move_sorter_core; no dependencies

package sms_pkg;

	// field widths
	localparam int unsigned SQUARE_W = 6;
	localparam int unsigned SCORE_W  = 32;
	localparam int unsigned KEY_W    = SCORE_W + SQUARE_W;

	// default store depth
	localparam int unsigned MAX_ENTRIES_DEF = 64;

	// controller to datapath commands
	typedef struct packed {
		logic insert;   // take the input beat into the sorted row
		logic emit;     // move the head entry into the output register
	} sms_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;   // output register empty or being taken this cycle
		logic last_one;   // exactly one stored entry left
	} sms_status_t;

	// key: score with sign flipped, then inverted square (lower square wins ties)
	function automatic logic [KEY_W-1:0] make_key(
		input logic [SQUARE_W-1:0] square,
		input logic [SCORE_W-1:0]  score
	);
		logic [SCORE_W-1:0] biased;
		biased = {~score[SCORE_W-1], score[SCORE_W-2:0]};
		return {biased, ~square};
	endfunction

endpackage

>>> hw/rtl/sms_ctrl.sv
// sms_ctrl: load / emit state machine of the scored move sorter
// depends on sms_pkg for the command and status structs

module sms_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 last,
	input  sms_pkg::sms_status_t status,
	output logic                 in_stall,
	output sms_pkg::sms_cmd_t    cmd
);

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;

	// commands: insert while loading, emit when the output register has room
	always_comb begin
		cmd.insert = (state_q == ST_LOAD) && in_valid;
		cmd.emit   = (state_q == ST_EMIT) && status.out_free;
		in_stall   = (state_q == ST_EMIT);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (cmd.insert && last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.emit && status.last_one) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/sms_datapath.sv
// sms_datapath: row of key cells with parallel compare-and-shift insertion,
// entry count and output register; depends on sms_pkg

module sms_datapath #(
	parameter int unsigned MAX_ENTRIES = sms_pkg::MAX_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sms_pkg::sms_cmd_t             cmd,
	input  logic [sms_pkg::SQUARE_W-1:0]  square,
	input  logic signed [sms_pkg::SCORE_W-1:0] score,
	input  logic                          out_stall,
	output sms_pkg::sms_status_t          status,
	output logic                          out_valid,
	output logic [sms_pkg::SQUARE_W-1:0]  sorted_square,
	output logic                          end_of_list
);

	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned KW    = sms_pkg::KEY_W;
	localparam int unsigned SW    = sms_pkg::SQUARE_W;

	logic [KW-1:0]          cell_q [MAX_ENTRIES];
	logic [CNT_W-1:0]       count_q;
	logic [MAX_ENTRIES-1:0] gt;
	logic [KW-1:0]          key;
	logic                   full;
	logic                   ins_en;
	logic                   out_valid_q;
	logic [SW-1:0]          sorted_square_q;
	logic                   end_of_list_q;

	assign key    = sms_pkg::make_key(square, score);
	assign full   = (count_q == CNT_W'(MAX_ENTRIES));
	assign ins_en = cmd.insert && !full;

	// one cell per entry: compare against own key, take new key or shift
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic          prev_gt;
		logic [KW-1:0] prev_key;
		logic [KW-1:0] next_key;

		// empty cells count as smaller than any key
		assign gt[i] = (CNT_W'(i) >= count_q) || (key > cell_q[i]);

		if (i == 0) begin : g_head
			assign prev_gt  = 1'b0;
			assign prev_key = key;
		end else begin : g_body
			assign prev_gt  = gt[i-1];
			assign prev_key = cell_q[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign next_key = cell_q[i];
		end else begin : g_inner
			assign next_key = cell_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (ins_en) begin
				if (gt[i] && !prev_gt) begin
					cell_q[i] <= key;
				end else if (prev_gt) begin
					cell_q[i] <= prev_key;
				end
			end else if (cmd.emit) begin
				cell_q[i] <= next_key;
			end
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ins_en) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.emit) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload: head cell, square recovered from inverted bits
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sorted_square_q <= ~cell_q[0][SW-1:0];
			end_of_list_q   <= status.last_one;
		end
	end

	always_comb begin
		status.out_free = !out_valid_q || !out_stall;
		status.last_one = (count_q == CNT_W'(1));
	end

	assign out_valid     = out_valid_q;
	assign sorted_square = sorted_square_q;
	assign end_of_list   = end_of_list_q;

endmodule

>>> hw/rtl/scored_move_sorter_core.sv
// scored_move_sorter_core: top level, joins sms_ctrl and sms_datapath
// depends on sms_pkg, sms_ctrl, sms_datapath
//
//   channel | handshake           | beat payload
//   --------+---------------------+--------------------------------
//   in      | in_valid / in_stall | square, score, last
//   out     | out_valid/out_stall | sorted_square, end_of_list
//
// loading takes one in beat per cycle: every cell of the key row compares
// and shifts in parallel, so an entry is sorted in as it arrives
// after a beat marked last, the N stored entries leave one per cycle while
// out is not stalled, by shifting the row toward its head;
// in_stall is high for that whole run
// reset clears the state machine, entry count and output valid; the key
// row is not cleared and needs no sweep
// beats beyond MAX_ENTRIES are taken and dropped

module scored_move_sorter_core #(
	parameter int unsigned MAX_ENTRIES = sms_pkg::MAX_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [sms_pkg::SQUARE_W-1:0]      square,
	input  logic signed [sms_pkg::SCORE_W-1:0] score,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sms_pkg::SQUARE_W-1:0]      sorted_square,
	output logic                              end_of_list
);

	sms_pkg::sms_cmd_t    cmd;
	sms_pkg::sms_status_t status;

	// sequencing
	sms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// key row and output register
	sms_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.square        (square),
		.score         (score),
		.out_stall     (out_stall),
		.status        (status),
		.out_valid     (out_valid),
		.sorted_square (sorted_square),
		.end_of_list   (end_of_list)
	);

endmodule

>>> tb/testbench.sv
// testbench for scored_move_sorter_core: streams scored move lists and checks the sorted squares
// depends on sms_pkg and scored_move_sorter_core; keeps its own sorted key row to predict each run

module testbench;

	localparam int unsigned SQ_W        = sms_pkg::SQUARE_W;
	localparam int unsigned SC_W        = sms_pkg::SCORE_W;
	localparam int unsigned ROW_DEPTH   = sms_pkg::MAX_ENTRIES_DEF;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLDOFF_AT  = 170;
	localparam int unsigned HOLDOFF_LEN = 400;

	typedef struct packed {
		logic [SQ_W-1:0]        square;
		logic signed [SC_W-1:0] score;
		logic                   last;
	} move_beat_t;

	typedef struct packed {
		logic [SQ_W-1:0] square;
		logic            eol;
	} sorted_move_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [SQ_W-1:0]        square = '0;
	logic signed [SC_W-1:0] score = '0;
	logic                   last = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [SQ_W-1:0]        sorted_square;
	logic                   end_of_list;

	move_beat_t   pending_moves[$];
	sorted_move_t expected_moves[$];
	logic [sms_pkg::KEY_W-1:0] key_row[$];

	move_beat_t   next_move;
	sorted_move_t got_move;
	int unsigned  planned_beats = 0;
	int unsigned  beats_in = 0;
	int unsigned  gap_left = 0;
	int unsigned  calm_left = 0;
	int unsigned  stall_run = 0;
	int unsigned  holdoff_left = 0;
	logic         holdoff_done = 1'b0;
	int unsigned  cycle_count = 0;
	int unsigned  errors = 0;

	scored_move_sorter_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.square        (square),
		.score         (score),
		.last          (last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sorted_square (sorted_square),
		.end_of_list   (end_of_list)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one line per mismatch
	task automatic report_mismatch(input string what, input int want, input int got);
		errors++;
		$display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
	endtask

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// sort one accepted beat into the key row, emit the run on last
	task automatic sort_in_move(input logic [SQ_W-1:0] sq, input logic [SC_W-1:0] sc,
		input logic is_last);
		logic [sms_pkg::KEY_W-1:0] key;
		int unsigned pos;
		sorted_move_t res;
		key = {~sc[SC_W-1], sc[SC_W-2:0], ~sq};
		if (key_row.size() < ROW_DEPTH) begin
			pos = key_row.size();
			while (pos > 0 && key > key_row[pos-1])
				pos--;
			key_row.insert(pos, key);
		end
		if (is_last) begin
			foreach (key_row[i]) begin
				res.square = ~key_row[i][SQ_W-1:0];
				res.eol    = (i == key_row.size() - 1);
				expected_moves.push_back(res);
			end
			key_row.delete();
		end
	endtask

	task automatic add_move(input int unsigned sq, input logic [SC_W-1:0] sc, input logic is_last);
		move_beat_t b;
		b.square = sq[SQ_W-1:0];
		b.score  = sc;
		b.last   = is_last;
		pending_moves.push_back(b);
	endtask

	// one list of random content, score style picked per list
	task automatic add_random_list(input int unsigned len);
		int unsigned mode;
		logic narrow_squares;
		logic [SC_W-1:0] sc;
		int unsigned sq;
		mode = $urandom_range(0, 3);
		narrow_squares = ($urandom_range(0, 3) == 0);
		for (int unsigned i = 0; i < len; i++) begin
			sq = narrow_squares ? $urandom_range(0, 3) : $urandom_range(0, 63);
			case (mode)
				1: sc = $urandom_range(0, 8) - 4;
				2: begin
					case ($urandom_range(0, 3))
						0: sc = 32'h8000_0000;
						1: sc = 32'h7fff_ffff;
						2: sc = '0;
						default: sc = '1;
					endcase
				end
				default: sc = $urandom();
			endcase
			add_move(sq, sc, i == len - 1);
		end
	endtask

	// input driver: holds a stalled beat, otherwise idles or launches the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			square    <= '0;
			score     <= '0;
			last      <= 1'b0;
			gap_left  <= 0;
			calm_left <= 0;
			beats_in  <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				sort_in_move(square, score, last);
				beats_in <= beats_in + 1;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_moves.size() != 0) begin
					next_move = pending_moves.pop_front();
					square   <= next_move.square;
					score    <= next_move.score;
					last     <= next_move.last;
					in_valid <= 1'b1;
					if (calm_left != 0) begin
						calm_left <= calm_left - 1;
						gap_left  <= 0;
					end else if ($urandom_range(0, 9) == 0) begin
						calm_left <= $urandom_range(5, 30);
						gap_left  <= 0;
					end else begin
						gap_left <= pick_idle_len();
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off once the stream is well under way
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left <= 0;
			holdoff_done <= 1'b0;
		end else if (!holdoff_done && beats_in >= HOLDOFF_AT) begin
			holdoff_left <= HOLDOFF_LEN;
			holdoff_done <= 1'b1;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end
	end

	// output stall: randomly chosen free and stalled runs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_run <= 0;
		end else if (holdoff_left != 0) begin
			out_stall <= 1'b1;
		end else if (stall_run != 0) begin
			stall_run <= stall_run - 1;
		end else if ($urandom_range(0, 1) == 0) begin
			out_stall <= 1'b0;
			stall_run <= $urandom_range(1, 40);
		end else begin
			out_stall <= 1'b1;
			stall_run <= pick_idle_len();
		end
	end

	// output monitor: compare each beat with the oldest expected square
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_moves.size() == 0) begin
				report_mismatch("unexpected result, square", -1, sorted_square);
			end else begin
				got_move = expected_moves.pop_front();
				if (sorted_square !== got_move.square)
					report_mismatch("sorted_square", got_move.square, sorted_square);
				if (end_of_list !== got_move.eol)
					report_mismatch("end_of_list", got_move.eol, end_of_list);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		// single-entry lists at the extremes
		add_move(0, 32'h7fff_ffff, 1'b1);
		add_move(63, 32'h8000_0000, 1'b1);
		// mixed signs around zero
		add_move(5, 32'h0000_0000, 1'b0);
		add_move(6, 32'hffff_ffff, 1'b0);
		add_move(7, 32'h0000_0001, 1'b0);
		add_move(0, 32'h8000_0000, 1'b0);
		add_move(63, 32'h7fff_ffff, 1'b0);
		add_move(10, 32'h0000_0000, 1'b1);
		// equal scores, lower square first
		add_move(40, 32'd100, 1'b0);
		add_move(3, 32'd100, 1'b0);
		add_move(63, 32'd100, 1'b1);
		// identical keys kept twice
		add_move(12, -32'sd7, 1'b0);
		add_move(12, -32'sd7, 1'b0);
		add_move(9, -32'sd7, 1'b1);
		// ties at both score extremes
		add_move(63, 32'h7fff_ffff, 1'b0);
		add_move(0, 32'h7fff_ffff, 1'b0);
		add_move(63, 32'h8000_0000, 1'b0);
		add_move(0, 32'h8000_0000, 1'b1);
		// full row: last beat dropped, then a longer overflow
		add_random_list(ROW_DEPTH + 1);
		add_random_list(ROW_DEPTH + 6);
		// mostly short lists, now and then a long one
		while (pending_moves.size() < 380) begin
			if ($urandom_range(0, 15) == 0)
				add_random_list($urandom_range(60, 72));
			else
				add_random_list($urandom_range(1, 12));
		end
		planned_beats = pending_moves.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (beats_in != planned_beats || expected_moves.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
